@@ hw/rtl/perspective_tile_plane_pixel_macros.svh @@
`ifndef PERSPECTIVE_TILE_PLANE_PIXEL_MACROS_SVH
`define PERSPECTIVE_TILE_PLANE_PIXEL_MACROS_SVH

// same-cycle implication, checked on clk with reset low as the guard
`define PTPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptpp_pkg.sv @@
`default_nettype none
package ptpp_pkg;

  localparam int SCR_W        = 320;
  localparam int SCR_H        = 240;
  localparam int SCR_HALF     = 160;
  localparam int HORIZON_BIAS = 19;
  localparam int NIB_MASK     = 'hF;

  // row distance fits 13 bits on every drawn row, step is 13.32
  localparam int DIST_W = 13;
  localparam int STEP_W = DIST_W + 32;

  localparam int QUEUE_DEPTH = 128;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_MAP   = 2'd0;
  localparam logic [1:0] KIND_TEXEL = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  localparam logic [2:0] CFG_CAM_X  = 3'd0;
  localparam logic [2:0] CFG_CAM_Y  = 3'd1;
  localparam logic [2:0] CFG_COS_A  = 3'd2;
  localparam logic [2:0] CFG_SIN_A  = 3'd3;
  localparam logic [2:0] CFG_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_HSCALE = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [15:0] data;
    logic [8:0]  sx;
    logic        drawn;
    logic [16:0] frame;
  } ptpp_sb_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [16:0] frame;
    logic        drawn;
  } ptpp_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/ptpp_ram.sv @@
`default_nettype none
module ptpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/ptpp_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per register stage
module ptpp_div #(
  parameter int N    = 17,
  parameter int M    = 8,
  parameter int SB_W = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [N-1:0]    in_dividend,
  input  wire logic [M-1:0]    in_divisor,
  input  wire logic [SB_W-1:0] in_sb,
  output logic                 out_valid,
  output logic      [N-1:0]    out_quot,
  output logic      [SB_W-1:0] out_sb
);

  logic            v_r   [N];
  logic [N-1:0]    dq_r  [N];
  logic [M-1:0]    rem_r [N];
  logic [M-1:0]    dv_r  [N];
  logic [SB_W-1:0] sb_r  [N];

  logic            v_nxt   [N];
  logic [N-1:0]    dq_nxt  [N];
  logic [M-1:0]    rem_nxt [N];
  logic [M-1:0]    dv_nxt  [N];
  logic [SB_W-1:0] sb_nxt  [N];

  always_comb begin
    logic [M:0]   trial;
    logic [N-1:0] dq_in;
    logic [M-1:0] rem_in;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        v_nxt[i]  = in_valid;
        dq_in     = in_dividend;
        rem_in    = '0;
        dv_nxt[i] = in_divisor;
        sb_nxt[i] = in_sb;
      end else begin
        v_nxt[i]  = v_r[i-1];
        dq_in     = dq_r[i-1];
        rem_in    = rem_r[i-1];
        dv_nxt[i] = dv_r[i-1];
        sb_nxt[i] = sb_r[i-1];
      end
      trial = {rem_in, dq_in[N-1]} - {1'b0, dv_nxt[i]};
      if (!trial[M]) begin
        rem_nxt[i] = trial[M-1:0];
        dq_nxt[i]  = {dq_in[N-2:0], 1'b1};
      end else begin
        rem_nxt[i] = {rem_in[M-2:0], dq_in[N-1]};
        dq_nxt[i]  = {dq_in[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_nxt[i];
      end
      dq_r[i]  <= dq_nxt[i];
      rem_r[i] <= rem_nxt[i];
      dv_r[i]  <= dv_nxt[i];
      sb_r[i]  <= sb_nxt[i];
    end
  end

  assign out_valid = v_r[N-1];
  assign out_quot  = dq_r[N-1];
  assign out_sb    = sb_r[N-1];

endmodule
`default_nettype wire

@@ hw/rtl/ptpp_proj.sv @@
`default_nettype none
// step vector, world point and integer part, five register stages
module ptpp_proj
  import ptpp_pkg::*;
#(
  parameter int SB_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [63:0]        cam_x,
  input  wire logic [63:0]        cam_y,
  input  wire logic [33:0]        cos_a,
  input  wire logic [33:0]        sin_a,
  input  wire logic               in_valid,
  input  wire logic [DIST_W-1:0]  in_dist,
  input  wire logic [STEP_W-1:0]  in_step,
  input  wire logic signed [9:0]  in_off,
  input  wire logic [SB_W-1:0]    in_sb,
  output logic                    out_valid,
  output logic      [31:0]        out_ix,
  output logic      [31:0]        out_iy,
  output logic      [SB_W-1:0]    out_sb
);

  localparam int QW = STEP_W - 32 + 1;
  localparam int PQ = 35 + QW;
  localparam int DW = DIST_W + 1 + 34;

  logic signed [34:0]   mul_x, mul_y;
  logic signed [16:0]   h_hi, h_lo;
  logic signed [QW-1:0] h_q;
  logic signed [DIST_W:0] dist_s;

  assign mul_x  = -$signed({sin_a[33], sin_a});
  assign mul_y  = $signed({cos_a[33], cos_a});
  assign h_hi   = $signed({1'b0, in_step[31:16]});
  assign h_lo   = $signed({1'b0, in_step[15:0]});
  assign h_q    = $signed({1'b0, in_step[STEP_W-1:32]});
  assign dist_s = $signed({1'b0, in_dist});

  // stage 1: partial products
  logic               v1_r;
  logic [SB_W-1:0]    sb1_r;
  logic signed [9:0]  off1_r;
  logic signed [51:0] pxh1_r, pxl1_r, pyh1_r, pyl1_r;
  logic signed [PQ-1:0] pxq1_r, pyq1_r;
  logic signed [DW-1:0] dc1_r, ds1_r;

  always_ff @(posedge clk) begin
    pxh1_r <= mul_x * h_hi;
    pxl1_r <= mul_x * h_lo;
    pxq1_r <= mul_x * h_q;
    pyh1_r <= mul_y * h_hi;
    pyl1_r <= mul_y * h_lo;
    pyq1_r <= mul_y * h_q;
    dc1_r  <= dist_s * $signed(cos_a);
    ds1_r  <= dist_s * $signed(sin_a);
    off1_r <= in_off;
    sb1_r  <= in_sb;
  end

  // stage 2: floored fraction part, camera plus distance term
  logic [68:0] tx2, ty2;
  assign tx2 = {pxh1_r[51], pxh1_r, 16'b0} + {{17{pxl1_r[51]}}, pxl1_r};
  assign ty2 = {pyh1_r[51], pyh1_r, 16'b0} + {{17{pyl1_r[51]}}, pyl1_r};

  logic               v2_r;
  logic [SB_W-1:0]    sb2_r;
  logic signed [9:0]  off2_r;
  logic [36:0]        fx2_r, fy2_r;
  logic [PQ-1:0]      pxq2_r, pyq2_r;
  logic [63:0]        bx2_r, by2_r;

  always_ff @(posedge clk) begin
    fx2_r  <= tx2[68:32];
    fy2_r  <= ty2[68:32];
    pxq2_r <= pxq1_r;
    pyq2_r <= pyq1_r;
    bx2_r  <= cam_x + {{(64-DW){dc1_r[DW-1]}}, dc1_r};
    by2_r  <= cam_y + {{(64-DW){ds1_r[DW-1]}}, ds1_r};
    off2_r <= off1_r;
    sb2_r  <= sb1_r;
  end

  // stage 3: per-pixel step
  logic               v3_r;
  logic [SB_W-1:0]    sb3_r;
  logic signed [9:0]  off3_r;
  logic [49:0]        ldx3_r, ldy3_r;
  logic [63:0]        bx3_r, by3_r;

  always_ff @(posedge clk) begin
    ldx3_r <= {{(50-PQ){pxq2_r[PQ-1]}}, pxq2_r} + {{13{fx2_r[36]}}, fx2_r};
    ldy3_r <= {{(50-PQ){pyq2_r[PQ-1]}}, pyq2_r} + {{13{fy2_r[36]}}, fy2_r};
    bx3_r  <= bx2_r;
    by3_r  <= by2_r;
    off3_r <= off2_r;
    sb3_r  <= sb2_r;
  end

  // stage 4: column offset times step
  logic               v4_r;
  logic [SB_W-1:0]    sb4_r;
  logic signed [59:0] mx4_r, my4_r;
  logic [63:0]        bx4_r, by4_r;

  always_ff @(posedge clk) begin
    mx4_r <= off3_r * $signed(ldx3_r);
    my4_r <= off3_r * $signed(ldy3_r);
    bx4_r <= bx3_r;
    by4_r <= by3_r;
    sb4_r <= sb3_r;
  end

  // stage 5: world point, wraps mod 2^64
  logic            v5_r;
  logic [SB_W-1:0] sb5_r;
  logic [63:0]     wx5_r, wy5_r;

  always_ff @(posedge clk) begin
    wx5_r <= bx4_r + {{4{mx4_r[59]}}, mx4_r};
    wy5_r <= by4_r + {{4{my4_r[59]}}, my4_r};
    sb5_r <= sb4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_ix    = wx5_r[63:32];
  assign out_iy    = wy5_r[63:32];
  assign out_sb    = sb5_r;

endmodule
`default_nettype wire

@@ hw/rtl/ptpp_fifo.sv @@
`default_nettype none
`include "perspective_tile_plane_pixel_macros.svh"
// result queue in a ram, read data register is the output register
module ptpp_fifo #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_data
);

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          pop;

  // cnt_r counts words in the ram not yet moved to the output register
  assign pop = (!ov_r || out_ready) && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    if (pop) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  ptpp_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_ptr_r),
    .wdata (push_data),
    .re    (pop),
    .raddr (rd_ptr_r),
    .rdata (out_data)
  );

  assign out_valid = ov_r;

  `PTPP_ASSERT_NOW(a_no_overflow, push, cnt_r < (AW+1)'(DEPTH), "result queue overflow")
  `PTPP_ASSERT_NEXT(a_queued_shown, cnt_r != '0 && !ov_r, ov_r, "queued word not shown")

endmodule
`default_nettype wire

@@ hw/rtl/perspective_tile_plane_pixel.sv @@
`default_nettype none
`include "perspective_tile_plane_pixel_macros.svh"
// Ground-plane pixel unit: one word per clock in while in_ready is high and,
// for render words, one result per clock out while out_ready is high (map,
// texel and unused words give none). A render word passes a 17-stage divider
// for the row distance and a 45-stage divider for the per-pixel step (one
// quotient bit per stage), then the step/world-point multiply stages, the map
// and texel ram reads, and the queue write and its output register. Map and
// texel writes ride the same pipeline and land in the rams at the stage where
// render words read them, so every word sees exactly the writes taken before
// it. Results wait in a 128-entry queue; in_ready drops only while 128 render
// results are outstanding. Configuration is taken at any time (cfg_ready is
// always high) and should be written while no words are in flight.
module perspective_tile_plane_pixel
  import ptpp_pkg::*;
#(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256,
  parameter int TILE_COUNT = 8,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_write_addr,
  input  wire logic [15:0] in_write_data,
  input  wire logic [8:0]  in_screen_x,
  input  wire logic [7:0]  in_screen_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pixel,
  output logic [16:0]      out_frame_offset,
  output logic             out_drawn
);

  localparam int COL_W     = $clog2(MAP_WIDTH);
  localparam int ROW_W     = $clog2(MAP_HEIGHT);
  localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int MAP_AW    = COL_W + ROW_W;
  localparam int TILE_W    = $clog2(TILE_COUNT);
  localparam int TEX_DEPTH = TILE_COUNT * 256;
  localparam int TEX_AW    = TILE_W + 8;
  localparam int TEXEL_W   = (PIXEL_BITS < 16) ? PIXEL_BITS : 16;
  localparam int SB_W      = $bits(ptpp_sb_t);
  localparam int RES_W     = $bits(ptpp_res_t);

  // configuration registers
  logic [63:0] cam_x_r, cam_y_r;
  logic [33:0] cos_a_r, sin_a_r;
  logic [11:0] height_r;
  logic [9:0]  hscale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cos_a_r  <= 34'h1_0000_0000;
      sin_a_r  <= '0;
      height_r <= 12'd384;
      hscale_r <= 10'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAM_X:  cam_x_r  <= cfg_data;
        CFG_CAM_Y:  cam_y_r  <= cfg_data;
        CFG_COS_A:  cos_a_r  <= cfg_data[33:0];
        CFG_SIN_A:  sin_a_r  <= cfg_data[33:0];
        CFG_HEIGHT: height_r <= cfg_data[11:0];
        CFG_HSCALE: hscale_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // credit count of render results not yet delivered
  logic [QUEUE_AW:0] pend_r, pend_nxt;
  logic              in_acc, pix_acc, out_acc;

  assign in_ready = pend_r < (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign in_acc   = in_valid && in_ready;
  assign pix_acc  = in_acc && (in_kind == KIND_PIXEL);
  assign out_acc  = out_valid && out_ready;
  assign pend_nxt = pend_r + (QUEUE_AW+1)'(pix_acc) - (QUEUE_AW+1)'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // entry: visibility and frame offset
  ptpp_sb_t    sb_in;
  logic [8:0]  first_row;

  assign first_row = 9'(height_r[11:4]) + 9'(HORIZON_BIAS);

  always_comb begin
    sb_in.kind  = in_kind;
    sb_in.addr  = in_write_addr;
    sb_in.data  = in_write_data;
    sb_in.sx    = in_screen_x;
    sb_in.drawn = (in_screen_x < 9'(SCR_W)) && (in_screen_y < 8'(SCR_H)) &&
                  ({1'b0, in_screen_y} >= first_row);
    sb_in.frame = 17'(in_screen_x) + 17'(in_screen_y) * 17'(SCR_W);
  end

  // row distance
  logic            d1_v;
  logic [16:0]     d1_q;
  logic [SB_W-1:0] d1_sb;

  ptpp_div #(
    .N    (17),
    .M    (8),
    .SB_W (SB_W)
  ) u_div_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_acc),
    .in_dividend ({height_r, 5'b0}),
    .in_divisor  (in_screen_y),
    .in_sb       (sb_in),
    .out_valid   (d1_v),
    .out_quot    (d1_q),
    .out_sb      (d1_sb)
  );

  // step = distance / horiz_scale in 13.32
  logic [9:0]               divisor;
  logic                     d2_v;
  logic [STEP_W-1:0]        d2_q;
  logic [DIST_W+SB_W-1:0]   d2_sb;

  assign divisor = (hscale_r == '0) ? 10'd1 : hscale_r;

  ptpp_div #(
    .N    (STEP_W),
    .M    (10),
    .SB_W (DIST_W + SB_W)
  ) u_div_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d1_v),
    .in_dividend ({d1_q[DIST_W-1:0], 32'b0}),
    .in_divisor  (divisor),
    .in_sb       ({d1_q[DIST_W-1:0], d1_sb}),
    .out_valid   (d2_v),
    .out_quot    (d2_q),
    .out_sb      (d2_sb)
  );

  ptpp_sb_t          sb_d2;
  logic signed [9:0] col_off;

  assign sb_d2   = ptpp_sb_t'(d2_sb[SB_W-1:0]);
  assign col_off = $signed({1'b0, sb_d2.sx}) - 10'sd160;

  logic            pj_v;
  logic [31:0]     pj_ix, pj_iy;
  logic [SB_W-1:0] pj_sb;

  ptpp_proj #(
    .SB_W (SB_W)
  ) u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .cam_x     (cam_x_r),
    .cam_y     (cam_y_r),
    .cos_a     (cos_a_r),
    .sin_a     (sin_a_r),
    .in_valid  (d2_v),
    .in_dist   (d2_sb[DIST_W+SB_W-1:SB_W]),
    .in_step   (d2_q),
    .in_off    (col_off),
    .in_sb     (d2_sb[SB_W-1:0]),
    .out_valid (pj_v),
    .out_ix    (pj_ix),
    .out_iy    (pj_iy),
    .out_sb    (pj_sb)
  );

  // tile map stage
  ptpp_sb_t          sb_pj;
  logic              map_we;
  logic [MAP_AW-1:0] map_raddr;
  logic [TILE_W-1:0] map_q;

  assign sb_pj  = ptpp_sb_t'(pj_sb);
  assign map_we = pj_v && (sb_pj.kind == KIND_MAP) &&
                  (32'(sb_pj.addr) < 32'(MAP_DEPTH)) &&
                  (32'(sb_pj.data) < 32'(TILE_COUNT));
  assign map_raddr = {pj_iy[4+ROW_W-1:4], pj_ix[4+COL_W-1:4]};

  ptpp_ram #(
    .WIDTH (TILE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (MAP_AW'(sb_pj.addr)),
    .wdata (TILE_W'(sb_pj.data)),
    .re    (1'b1),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  logic       m1_v_r;
  ptpp_sb_t   m1_sb_r;
  logic [7:0] m1_tx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= pj_v;
    end
    m1_sb_r <= sb_pj;
    m1_tx_r <= {pj_iy[3:0] & 4'(NIB_MASK), pj_ix[3:0] & 4'(NIB_MASK)};
  end

  // texel stage
  logic               tex_we;
  logic [TEXEL_W-1:0] tex_q;

  assign tex_we = m1_v_r && (m1_sb_r.kind == KIND_TEXEL) &&
                  (32'(m1_sb_r.addr) < 32'(TEX_DEPTH));

  ptpp_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (TEX_DEPTH)
  ) u_texels (
    .clk   (clk),
    .we    (tex_we),
    .waddr (TEX_AW'(m1_sb_r.addr)),
    .wdata (m1_sb_r.data[TEXEL_W-1:0]),
    .re    (1'b1),
    .raddr ({map_q, m1_tx_r}),
    .rdata (tex_q)
  );

  logic     m2_v_r;
  ptpp_sb_t m2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
    m2_sb_r <= m1_sb_r;
  end

  // result queue
  ptpp_res_t res_push, res_out;
  logic      q_push;
  logic [RES_W-1:0] res_bits;

  assign q_push         = m2_v_r && (m2_sb_r.kind == KIND_PIXEL);
  assign res_push.pixel = m2_sb_r.drawn ? 16'(tex_q) : 16'd0;
  assign res_push.frame = m2_sb_r.frame;
  assign res_push.drawn = m2_sb_r.drawn;

  ptpp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (res_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_bits)
  );

  assign res_out          = ptpp_res_t'(res_bits);
  assign out_pixel        = res_out.pixel;
  assign out_frame_offset = res_out.frame;
  assign out_drawn        = res_out.drawn;

  `PTPP_ASSERT_NOW(a_pend_bound, 1'b1, pend_r <= (QUEUE_AW+1)'(QUEUE_DEPTH), "credit overrun")
  `PTPP_ASSERT_NOW(a_out_has_credit, out_valid, pend_r != '0, "result without credit")

endmodule
`default_nettype wire

@@ bench/perspective_tile_plane_pixel_tb.sv @@
`timescale 1ns / 100ps
module perspective_tile_plane_pixel_tb
  import ptpp_pkg::*;
();

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [15:0] pixel;
    logic [16:0] frame;
    logic        drawn;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_write_addr = '0;
  logic [15:0] in_write_data = '0;
  logic [8:0]  in_screen_x = '0;
  logic [7:0]  in_screen_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pixel;
  logic [16:0] out_frame_offset;
  logic        out_drawn;

  perspective_tile_plane_pixel i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_write_addr(in_write_addr), .in_write_data(in_write_data),
    .in_screen_x(in_screen_x), .in_screen_y(in_screen_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel(out_pixel),
    .out_frame_offset(out_frame_offset), .out_drawn(out_drawn)
  );

  // camera and memory shadow
  logic [63:0]        cam_x_q, cam_y_q;
  logic signed [33:0] cos_q, sin_q;
  logic [11:0]        height_q;
  logic [9:0]         hscale_q;
  logic [2:0]         map_shadow [0:65535];
  logic               map_known [0:65535];
  logic [15:0]        texel_shadow [0:2047];
  logic               texel_known [0:2047];

  pixel_res_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0, hold_seq = 0, hold_seen = 0, hold_left = 0;
  int mismatches = 0, pixels_checked = 0, words_sent = 0, renders_sent = 0;
  int cfg_writes = 0;

  initial forever #10 clk = ~clk;

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", expected_pixels.size());
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result pixel %h frame %0d drawn %b",
                   out_pixel, out_frame_offset, out_drawn);
      end else begin
        exp_res = expected_pixels.pop_front();
        if (out_pixel !== exp_res.pixel || out_frame_offset !== exp_res.frame ||
            out_drawn !== exp_res.drawn) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pixel %h frame %0d drawn %b, got %h %0d %b",
                     exp_res.pixel, exp_res.frame, exp_res.drawn,
                     out_pixel, out_frame_offset, out_drawn);
        end
      end
    end
  end

  // ground point seen by a screen pixel
  function automatic void locate_ground(input logic [8:0] sx, input logic [7:0] sy,
                                        output logic drawn, output logic [15:0] map_ix,
                                        output logic [10:0] texel_ix);
    logic [16:0] row_d, quo, remn;
    logic [9:0] divisor;
    logic [63:0] frac;
    longint step_h, ldx, ldy, off, wx, wy;
    logic signed [127:0] prod;
    logic [31:0] ix, iy;
    drawn = 1'b0;
    map_ix = '0;
    texel_ix = '0;
    if (sx < SCR_W && sy < SCR_H && sy >= (height_q >> 4) + HORIZON_BIAS) begin
      divisor = (hscale_q == 0) ? 10'd1 : hscale_q;
      row_d = {height_q, 5'b0} / sy;
      quo = row_d / divisor;
      remn = row_d % divisor;
      frac = {15'b0, remn, 32'b0} / divisor;
      step_h = longint'({quo, 32'b0}) + longint'(frac);
      prod = longint'(-longint'(sin_q)) * step_h;
      ldx = prod[95:32];
      prod = longint'(cos_q) * step_h;
      ldy = prod[95:32];
      off = longint'(sx) - SCR_HALF;
      wx = cam_x_q + longint'(row_d) * longint'(cos_q) + off * ldx;
      wy = cam_y_q + longint'(row_d) * longint'(sin_q) + off * ldy;
      ix = wx[63:32];
      iy = wy[63:32];
      map_ix = {iy[11:4], ix[11:4]};
      drawn = 1'b1;
      texel_ix = {map_shadow[map_ix], iy[3:0], ix[3:0]};
    end
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [15:0] data, input logic [8:0] sx,
                           input logic [7:0] sy);
    logic drawn;
    logic [15:0] map_ix;
    logic [10:0] tix;
    pixel_res_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    case (kind)
      KIND_MAP: begin
        if (data < 8) begin
          map_shadow[addr] = data[2:0];
          map_known[addr] = 1'b1;
        end
      end
      KIND_TEXEL: begin
        if (addr < 2048) begin
          texel_shadow[addr[10:0]] = data;
          texel_known[addr[10:0]] = 1'b1;
        end
      end
      KIND_PIXEL: begin
        locate_ground(sx, sy, drawn, map_ix, tix);
        res.drawn = drawn;
        res.pixel = drawn ? texel_shadow[tix] : 16'h0;
        res.frame = 17'(sx + SCR_W * sy);
        expected_pixels.push_back(res);
        renders_sent++;
      end
      default: ;
    endcase
    in_valid <= 1'b1;
    in_kind <= kind;
    in_write_addr <= addr;
    in_write_data <= data;
    in_screen_x <= sx;
    in_screen_y <= sy;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // fills in any unwritten map cell or texel the pixel would read, then sends the pixel
  task automatic render_pixel(input logic [8:0] sx, input logic [7:0] sy);
    logic drawn;
    logic [15:0] map_ix;
    logic [10:0] tix;
    locate_ground(sx, sy, drawn, map_ix, tix);
    if (drawn && !map_known[map_ix])
      send_word(KIND_MAP, map_ix, 16'($urandom_range(7)), 9'($urandom), 8'($urandom));
    locate_ground(sx, sy, drawn, map_ix, tix);
    if (drawn && !texel_known[tix])
      send_word(KIND_TEXEL, {5'b0, tix}, 16'($urandom), 9'($urandom), 8'($urandom));
    send_word(KIND_PIXEL, 16'($urandom), 16'($urandom), sx, sy);
  endtask

  task automatic end_stream;
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained;
    end_stream();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    case (idx)
      CFG_CAM_X:  cam_x_q = value;
      CFG_CAM_Y:  cam_y_q = value;
      CFG_COS_A:  cos_q = value[33:0];
      CFG_SIN_A:  sin_q = value[33:0];
      CFG_HEIGHT: height_q = value[11:0];
      CFG_HSCALE: hscale_q = value[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_camera(input logic [63:0] cx, input logic [63:0] cy,
                            input longint c, input longint s,
                            input int h, input int hs);
    write_reg(CFG_CAM_X, cx);
    write_reg(CFG_CAM_Y, cy);
    write_reg(CFG_COS_A, c);
    write_reg(CFG_SIN_A, s);
    write_reg(CFG_HEIGHT, 64'(h));
    write_reg(CFG_HSCALE, 64'(hs));
  endtask

  function automatic longint rand_trig();
    longint v;
    v = longint'($urandom);
    if ($urandom_range(7) == 0) v = 64'h1_0000_0000;
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic random_word;
    int r, first;
    logic [8:0] sx;
    logic [7:0] sy;
    r = $urandom_range(99);
    first = (height_q >> 4) + HORIZON_BIAS;
    if (r < 72) begin
      sx = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(319));
      if ($urandom_range(9) == 0 || first > 239) sy = 8'($urandom);
      else sy = 8'($urandom_range(239, first));
      render_pixel(sx, sy);
    end else if (r < 82) begin
      send_word(KIND_MAP, 16'($urandom),
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(7)),
                9'($urandom), 8'($urandom));
    end else if (r < 94) begin
      send_word(KIND_TEXEL,
                $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2047)),
                16'($urandom), 9'($urandom), 8'($urandom));
    end else begin
      send_word(KIND_UNUSED, 16'($urandom), 16'($urandom), 9'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_reset_camera;
    render_pixel(9'd0, 8'd239);
    render_pixel(9'd319, 8'd239);
    render_pixel(9'd160, 8'd43);
    render_pixel(9'd5, 8'd42);
    wait_drained();
  endtask

  task automatic test_directed;
    // off screen, above horizon, unused kind, rejected writes
    render_pixel(9'd320, 8'd100);
    render_pixel(9'd511, 8'd255);
    render_pixel(9'd10, 8'd240);
    render_pixel(9'd10, 8'd0);
    send_word(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 9'h1FF, 8'hFF);
    send_word(KIND_MAP, 16'hFFFF, 16'd8, 9'd0, 8'd0);
    send_word(KIND_MAP, 16'h0000, 16'hFFFF, 9'd0, 8'd0);
    send_word(KIND_TEXEL, 16'd2048, 16'hFFFF, 9'd0, 8'd0);
    send_word(KIND_TEXEL, 16'hFFFF, 16'h0000, 9'd0, 8'd0);
    wait_drained();
    // zero divisor, lowest and highest height, extreme angles
    set_camera(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
               -64'sh1_0000_0000, 64'sh1_0000_0000, 0, 0);
    render_pixel(9'd0, 8'd19);
    render_pixel(9'd319, 8'd18);
    render_pixel(9'd160, 8'd239);
    wait_drained();
    set_camera(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'sh1_0000_0000,
               -64'sh1_0000_0000, 3535, 1023);
    render_pixel(9'd0, 8'd239);
    render_pixel(9'd319, 8'd239);
    render_pixel(9'd100, 8'd238);
    wait_drained();
  endtask

  task automatic test_random_phase(input int items, input int idle, input int stall);
    set_camera({$urandom, $urandom}, {$urandom, $urandom}, rand_trig(), rand_trig(),
               $urandom_range(3535), $urandom_range(1023, 1));
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (items) random_word();
    wait_drained();
  endtask

  // output blocked long enough for the result queue to fill and stall input
  task automatic test_backpressure;
    set_camera(64'h0000_0010_8000_0000, 64'h0000_0020_0000_0000,
               64'sh1_0000_0000, 0, 384, 64);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 600;
    hold_seq++;
    repeat (160) render_pixel(9'($urandom_range(319)), 8'($urandom_range(239, 43)));
    wait_drained();
  endtask

  initial begin
    cam_x_q = '0;
    cam_y_q = '0;
    cos_q = 34'sh1_0000_0000;
    sin_q = '0;
    height_q = 12'd384;
    hscale_q = 10'd64;
    for (int i = 0; i < 65536; i++) map_known[i] = 1'b0;
    for (int i = 0; i < 2048; i++) texel_known[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_camera();
    test_directed();
    test_random_phase(75, 0, 0);
    test_random_phase(75, 58, 0);
    test_random_phase(75, 0, 58);
    test_random_phase(75, 36, 36);
    test_backpressure();
    test_random_phase(50, 36, 36);
    $display("sent %0d words (%0d renders), checked %0d pixels, %0d register writes",
             words_sent, renders_sent, pixels_checked, cfg_writes);
    $display("covered directed edges, random camera settings and a stalled output");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_pixels.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
